@@ src/scene_peak_auto_attenuator_macros.svh @@
// assertion macros for the scene peak auto attenuator
// expects i_clk and i_rst_n in the module that uses them
`ifndef SCENE_PEAK_AUTO_ATTENUATOR_MACROS_SVH
`define SCENE_PEAK_AUTO_ATTENUATOR_MACROS_SVH
`ifndef ASSERT_OFF
`define SPAA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);
`define SPAA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);
`else
`define SPAA_ASSERT_IMP(label, ante, cons, msg)
`define SPAA_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

@@ src/spaa_pkg.sv @@
// shared types and constants of the scene peak auto attenuator
// no dependencies
`default_nettype none
package spaa_pkg;

    localparam int TOLERANCE_Q8   = 64;
    localparam int FLOOR_Q8       = -36864;
    localparam int LIMITER_MIN_Q8 = -6144;
    localparam int LIMITER_MAX_Q8 = 0;
    localparam int SCENE_VER_OK   = 1;

    typedef enum logic [1:0] {
        ACT_START  = 2'd0,
        ACT_PEAK   = 2'd1,
        ACT_FINISH = 2'd2,
        ACT_NONE   = 2'd3
    } t_act;

    typedef enum logic [2:0] {
        KIND_NONE     = 3'd0,
        KIND_ATTEN    = 3'd1,
        KIND_RESTORE  = 3'd2,
        KIND_STARTED  = 3'd3,
        KIND_REJECTED = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        CFG_SCENE_VERSION = 3'd0,
        CFG_LIMITER_LEVEL = 3'd1,
        CFG_AUTO_ENABLE   = 3'd2,
        CFG_HYSTERESIS    = 3'd3,
        CFG_MAX_STEP      = 3'd4,
        CFG_MIN_INTERVAL  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0]         scene_version;
        logic signed [14:0] limiter_level;
        logic               auto_enable;
        logic [11:0]        hysteresis;
        logic [12:0]        max_step;
        logic [15:0]        min_interval;
    } t_cfg;

    // one classified event as it travels from front to back
    typedef struct packed {
        t_act               act;
        logic               start_ok;
        logic signed [16:0] base_level;
        logic               auto_en;
        logic signed [14:0] limiter;
        logic signed [16:0] peak;
        logic               peak_ok;
        logic [47:0]        now;
        logic signed [16:0] req;
        logic               req_ok;
        logic signed [16:0] ceil;
        logic               ceil_ok;
        logic signed [17:0] req_hi;
        logic signed [17:0] req_lo;
    } t_item;

endpackage
`default_nettype wire

@@ src/scene_peak_auto_attenuator.sv @@
// top level of the scene peak auto attenuator: config registers, front, queue, back
// depends on spaa_pkg, spaa_front, spaa_queue, spaa_back
//
//   channel   direction  handshake              payload
//   event     in         i_valid / o_stall      i_action .. i_ceiling_valid
//   result    out        o_valid / i_stall      o_result_kind, o_target_level, o_from_safety
//   config    in         i_cfg_we (no wait)     i_cfg_idx, i_cfg_data
//
// one item per cycle while the result side does not stall; an item taken is written
// into the queue, then into the output register by the single back end update of session state
// o_stall rises only when the queue of QUEUE_DEPTH items is full
// a stalled result holds in the output register while the queue keeps filling
// synchronous active low reset restores config defaults and closes the session
`default_nettype none
module scene_peak_auto_attenuator
    import spaa_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [15:0]        i_cfg_data,
    // event channel
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_action,
    input  wire logic signed [16:0] i_peak_level,
    input  wire logic               i_peak_valid,
    input  wire logic [47:0]        i_now_time,
    input  wire logic signed [16:0] i_requested_level,
    input  wire logic               i_requested_valid,
    input  wire logic signed [16:0] i_ceiling_level,
    input  wire logic               i_ceiling_valid,
    // result channel
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [2:0]              o_result_kind,
    output logic signed [16:0]      o_target_level,
    output logic                    o_from_safety
);

    t_cfg  r_cfg;
    t_item front_item;
    t_item head_item;
    logic  q_full;
    logic  q_head_valid;
    logic  q_pop;
    logic  q_push;

    // config registers; the user writes them only while idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scene_version <= 8'd1;
            r_cfg.limiter_level <= -15'sd256;
            r_cfg.auto_enable   <= 1'b1;
            r_cfg.hysteresis    <= 12'd128;
            r_cfg.max_step      <= 13'd768;
            r_cfg.min_interval  <= 16'd250;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SCENE_VERSION: r_cfg.scene_version <= i_cfg_data[7:0];
                CFG_LIMITER_LEVEL: r_cfg.limiter_level <= i_cfg_data[14:0];
                CFG_AUTO_ENABLE:   r_cfg.auto_enable   <= i_cfg_data[0];
                CFG_HYSTERESIS:    r_cfg.hysteresis    <= i_cfg_data[11:0];
                CFG_MAX_STEP:      r_cfg.max_step      <= i_cfg_data[12:0];
                CFG_MIN_INTERVAL:  r_cfg.min_interval  <= i_cfg_data;
                default: begin
                    // indexes past the register list are ignored
                end
            endcase
        end
    end

    // taking an item only needs room in the queue
    assign o_stall = q_full;
    assign q_push  = i_valid && !q_full;

    spaa_front u_front (
        .i_cfg             (r_cfg),
        .i_action          (i_action),
        .i_peak_level      (i_peak_level),
        .i_peak_valid      (i_peak_valid),
        .i_now_time        (i_now_time),
        .i_requested_level (i_requested_level),
        .i_requested_valid (i_requested_valid),
        .i_ceiling_level   (i_ceiling_level),
        .i_ceiling_valid   (i_ceiling_valid),
        .o_item            (front_item)
    );

    spaa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_data       (front_item),
        .i_pop        (q_pop),
        .o_full       (q_full),
        .o_head_valid (q_head_valid),
        .o_head       (head_item)
    );

    // back end pops whenever its output register is free or being taken
    spaa_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_head_valid   (q_head_valid),
        .i_head         (head_item),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_kind  (o_result_kind),
        .o_target_level (o_target_level),
        .o_from_safety  (o_from_safety)
    );

endmodule
`default_nettype wire

@@ src/spaa_front.sv @@
// front end: decodes an event and precomputes what needs no session state
// depends on spaa_pkg
`default_nettype none
module spaa_front
    import spaa_pkg::*;
(
    input  wire t_cfg               i_cfg,
    input  wire logic [1:0]         i_action,
    input  wire logic signed [16:0] i_peak_level,
    input  wire logic               i_peak_valid,
    input  wire logic [47:0]        i_now_time,
    input  wire logic signed [16:0] i_requested_level,
    input  wire logic               i_requested_valid,
    input  wire logic signed [16:0] i_ceiling_level,
    input  wire logic               i_ceiling_valid,
    output t_item                   o_item
);

    logic scene_ok;

    always_comb begin
        scene_ok = (i_cfg.scene_version == 8'(SCENE_VER_OK)) &&
                   (i_cfg.limiter_level <= LIMITER_MAX_Q8) &&
                   (i_cfg.limiter_level >= LIMITER_MIN_Q8);

        o_item.act        = t_act'(i_action);
        o_item.start_ok   = scene_ok && i_requested_valid && i_ceiling_valid;
        o_item.base_level = (i_requested_level < i_ceiling_level) ?
                            i_requested_level : i_ceiling_level;
        o_item.auto_en    = i_cfg.auto_enable;
        o_item.limiter    = i_cfg.limiter_level;
        o_item.peak       = i_peak_level;
        o_item.peak_ok    = i_peak_valid;
        o_item.now        = i_now_time;
        o_item.req        = i_requested_level;
        o_item.req_ok     = i_requested_valid;
        o_item.ceil       = i_ceiling_level;
        o_item.ceil_ok    = i_ceiling_valid;
        // restore and attenuate margins around the requested volume
        o_item.req_hi     = {i_requested_level[16], i_requested_level} +
                            {6'd0, i_cfg.hysteresis};
        o_item.req_lo     = {i_requested_level[16], i_requested_level} -
                            {6'd0, i_cfg.hysteresis};
    end

endmodule
`default_nettype wire

@@ src/spaa_queue.sv @@
// short fifo of classified items between front and back
// depends on spaa_pkg and the assertion macro header
`default_nettype none
`include "scene_peak_auto_attenuator_macros.svh"
module spaa_queue
    import spaa_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_data,
    input  wire logic  i_pop,
    output logic       o_full,
    output logic       o_head_valid,
    output t_item      o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= wrap_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= wrap_inc(r_rd_ptr);
            end
            priority if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    `SPAA_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CNT_W'(DEPTH), "queue overfilled")
    `SPAA_ASSERT_IMP(a_pop_nonempty, i_pop, r_count != '0, "pop from empty queue")
    `SPAA_ASSERT_NXT(a_push_counts, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "push lost")

endmodule
`default_nettype wire

@@ src/spaa_back.sv @@
// back end: session state, start, peak and finish decisions, output register
// depends on spaa_pkg and the assertion macro header
`default_nettype none
`include "scene_peak_auto_attenuator_macros.svh"
module spaa_back
    import spaa_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cfg               i_cfg,
    input  wire logic               i_head_valid,
    input  wire t_item              i_head,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [2:0]              o_result_kind,
    output logic signed [16:0]      o_target_level,
    output logic                    o_from_safety
);

    logic               r_active, n_active;
    logic               r_auto, n_auto;
    logic               r_ovr, n_ovr;
    logic signed [16:0] r_base, n_base;
    logic signed [16:0] r_last_cmd, n_last_cmd;
    logic signed [14:0] r_lim, n_lim;
    logic [47:0]        r_last_time, n_last_time;

    logic               r_out_valid;
    t_kind              r_kind, n_kind;
    logic signed [16:0] r_target, n_target;
    logic               r_safety, n_safety;

    logic signed [17:0] drift;
    logic               near;
    logic signed [18:0] lim_plus_h;
    logic               peak_high;
    logic signed [17:0] over;
    logic signed [17:0] step_cap;
    logic signed [17:0] step;
    logic signed [18:0] tgt_raw;
    logic signed [16:0] tgt;
    logic               time_ok;
    logic [47:0]        elapsed;
    logic signed [16:0] rst_tgt;
    logic               ovr_fin;

    assign o_pop = i_head_valid && (!r_out_valid || !i_stall);

    always_comb begin
        drift      = {i_head.req[16], i_head.req} - {r_last_cmd[16], r_last_cmd};
        near       = i_head.req_ok && (drift >= -TOLERANCE_Q8) && (drift <= TOLERANCE_Q8);
        lim_plus_h = {{4{r_lim[14]}}, r_lim} + {7'd0, i_cfg.hysteresis};
        peak_high  = i_head.peak > lim_plus_h;
        over       = {i_head.peak[16], i_head.peak} - {{3{r_lim[14]}}, r_lim};
        step_cap   = {5'd0, i_cfg.max_step};
        step       = (over > step_cap) ? step_cap : over;
        tgt_raw    = {{2{i_head.req[16]}}, i_head.req} - {step[17], step};
        tgt        = (tgt_raw < FLOOR_Q8) ? 17'(FLOOR_Q8) : tgt_raw[16:0];
        elapsed    = i_head.now - r_last_time;
        time_ok    = (i_head.now >= r_last_time) && (elapsed >= {32'd0, i_cfg.min_interval});
        rst_tgt    = (i_head.ceil_ok && (i_head.ceil < r_base)) ? i_head.ceil : r_base;
        ovr_fin    = r_ovr || !near;

        n_active    = r_active;
        n_auto      = r_auto;
        n_ovr       = r_ovr;
        n_base      = r_base;
        n_last_cmd  = r_last_cmd;
        n_lim       = r_lim;
        n_last_time = r_last_time;
        n_kind      = KIND_NONE;
        n_target    = '0;
        n_safety    = 1'b0;

        unique case (i_head.act)
            ACT_START: begin
                if (i_head.start_ok) begin
                    n_active    = 1'b1;
                    n_auto      = i_head.auto_en;
                    n_ovr       = 1'b0;
                    n_base      = i_head.base_level;
                    n_last_cmd  = i_head.base_level;
                    n_lim       = i_head.limiter;
                    n_last_time = '0;
                    n_kind      = KIND_STARTED;
                end else begin
                    n_kind = KIND_REJECTED;
                end
            end
            ACT_PEAK: begin
                if (!r_active || !r_auto || r_ovr || !i_head.peak_ok || !near) begin
                    if (r_active && !near) begin
                        n_ovr = 1'b1;
                    end
                end else if (time_ok && peak_high && (tgt < i_head.req_lo)) begin
                    n_last_cmd  = tgt;
                    n_last_time = i_head.now;
                    n_kind      = KIND_ATTEN;
                    n_target    = tgt;
                    n_safety    = 1'b1;
                end
            end
            ACT_FINISH: begin
                if (r_active) begin
                    n_ovr    = ovr_fin;
                    n_active = 1'b0;
                    if (r_auto && !ovr_fin && (rst_tgt > i_head.req_hi)) begin
                        n_kind   = KIND_RESTORE;
                        n_target = rst_tgt;
                    end
                end
            end
            ACT_NONE: begin
                n_kind = KIND_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_auto      <= 1'b0;
            r_ovr       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_active <= n_active;
                r_auto   <= n_auto;
                r_ovr    <= n_ovr;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_base      <= n_base;
            r_last_cmd  <= n_last_cmd;
            r_lim       <= n_lim;
            r_last_time <= n_last_time;
            r_kind      <= n_kind;
            r_target    <= n_target;
            r_safety    <= n_safety;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_kind  = r_kind;
    assign o_target_level = r_target;
    assign o_from_safety  = r_safety;

    `SPAA_ASSERT_IMP(a_safety_kind, r_out_valid && r_safety,
        r_kind == KIND_ATTEN, "safety flag on non attenuate")
    `SPAA_ASSERT_IMP(a_zero_target,
        r_out_valid && (r_kind == KIND_NONE || r_kind == KIND_STARTED ||
        r_kind == KIND_REJECTED), r_target == '0, "target on non level result")
    `SPAA_ASSERT_NXT(a_start_opens, o_pop && i_head.act == ACT_START && i_head.start_ok,
        r_active, "accepted start left session closed")

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
// self-checking testbench of the scene peak auto attenuator: directed table, then random phases
// depends on spaa_pkg and scene_peak_auto_attenuator from src
module testbench
    import spaa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // one event as offered on the input channel
    typedef struct {
        t_act               action;
        logic signed [16:0] peak;
        logic               peak_ok;
        logic [47:0]        now;
        logic signed [16:0] req;
        logic               req_ok;
        logic signed [16:0] ceil;
        logic               ceil_ok;
    } t_event;

    // one response as seen on the result channel
    typedef struct {
        t_kind              kind;
        logic signed [16:0] target;
        logic               safety;
    } t_response;

    // directed row; when typed is set the response is written out by hand
    typedef struct {
        t_act   action;
        int     peak;
        bit     peak_ok;
        longint now;
        int     req;
        bit     req_ok;
        int     ceil;
        bit     ceil_ok;
        bit     typed;
        t_kind  kind;
        int     target;
    } t_row;

    // register set for one random phase; roll draws fresh values at run time
    typedef struct {
        int version;
        int limiter;
        bit auto_en;
        int hyst;
        int step;
        int interval;
        int items;
        bit roll;
    } t_setting;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_idx;
    logic [15:0]        i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_action;
    logic signed [16:0] i_peak_level;
    logic               i_peak_valid;
    logic [47:0]        i_now_time;
    logic signed [16:0] i_requested_level;
    logic               i_requested_valid;
    logic signed [16:0] i_ceiling_level;
    logic               i_ceiling_valid;
    logic               o_valid;
    logic               i_stall;
    logic [2:0]         o_result_kind;
    logic signed [16:0] o_target_level;
    logic               o_from_safety;

    scene_peak_auto_attenuator i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_action          (i_action),
        .i_peak_level      (i_peak_level),
        .i_peak_valid      (i_peak_valid),
        .i_now_time        (i_now_time),
        .i_requested_level (i_requested_level),
        .i_requested_valid (i_requested_valid),
        .i_ceiling_level   (i_ceiling_level),
        .i_ceiling_valid   (i_ceiling_valid),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_result_kind     (o_result_kind),
        .o_target_level    (o_target_level),
        .o_from_safety     (o_from_safety)
    );

    // register copy held by the predictor
    int          cfg_version;
    int          cfg_limiter;
    bit          cfg_auto;
    int          cfg_hyst;
    int          cfg_step;
    logic [15:0] cfg_interval;

    // scene session state held by the predictor
    bit          in_scene;
    bit          auto_on;
    bit          override_flag;
    int          base_level;
    int          last_cmd;
    int          limiter_held;
    logic [47:0] last_atten_ms;

    t_response   pending_responses[$];
    int          errors;
    bit          steady;           // no idling on either side while set
    logic [47:0] ms_now;           // running meter time for well-formed sequences
    t_response   got_want;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #5ms;
        $display("scene_peak_auto_attenuator test failed");
        $finish;
    end

    // works out the response of the block to one event and advances the session state
    function automatic t_response scene_response(t_event ev);
        t_response res;
        bit        near;
        int        peak;
        int        req;
        int        ceil;
        int        over;
        int        goal;
        res  = '{KIND_NONE, 17'sd0, 1'b0};
        peak = ev.peak;
        req  = ev.req;
        ceil = ev.ceil;
        // requested volume must sit within a quarter dB of the last command
        near = ev.req_ok && (req - last_cmd <= TOLERANCE_Q8) && (last_cmd - req <= TOLERANCE_Q8);
        case (ev.action)
            ACT_START: begin
                if (cfg_version != SCENE_VER_OK || cfg_limiter > LIMITER_MAX_Q8 ||
                    cfg_limiter < LIMITER_MIN_Q8 || !ev.req_ok || !ev.ceil_ok) begin
                    res.kind = KIND_REJECTED;
                end else begin
                    in_scene      = 1'b1;
                    auto_on       = cfg_auto;
                    override_flag = 1'b0;
                    base_level    = (req < ceil) ? req : ceil;
                    last_cmd      = base_level;
                    limiter_held  = cfg_limiter;
                    last_atten_ms = '0;
                    res.kind      = KIND_STARTED;
                end
            end
            ACT_PEAK: begin
                if (!in_scene || !auto_on || override_flag || !ev.peak_ok || !near) begin
                    if (in_scene && !near)
                        override_flag = 1'b1;
                end else if (ev.now >= last_atten_ms && ev.now - last_atten_ms >= cfg_interval &&
                             peak > limiter_held + cfg_hyst) begin
                    over = peak - limiter_held;
                    if (over > cfg_step)
                        over = cfg_step;
                    goal = req - over;
                    if (goal < FLOOR_Q8)
                        goal = FLOOR_Q8;
                    // only a step that clears the hysteresis counts as an action
                    if (goal < req - cfg_hyst) begin
                        last_cmd      = goal;
                        last_atten_ms = ev.now;
                        res           = '{KIND_ATTEN, 17'(goal), 1'b1};
                    end
                end
            end
            ACT_FINISH: begin
                if (in_scene) begin
                    if (!near)
                        override_flag = 1'b1;
                    if (auto_on && !override_flag) begin
                        goal = base_level;
                        if (ev.ceil_ok && ceil < goal)
                            goal = ceil;
                        if (goal > req + cfg_hyst)
                            res = '{KIND_RESTORE, 17'(goal), 1'b0};
                    end
                    in_scene = 1'b0;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // draws one event: mostly well-formed scenes built on the predicted state, some noise
    task automatic make_event(output t_event ev);
        int pick;
        int delta;
        pick       = $urandom_range(0, 99);
        // noise over every bit of every field
        ev.action  = t_act'(2'($urandom_range(0, 3)));
        ev.peak    = 17'($urandom);
        ev.peak_ok = 1'($urandom);
        ev.now     = 48'({$urandom, $urandom});
        ev.req     = 17'($urandom);
        ev.req_ok  = 1'($urandom);
        ev.ceil    = 17'($urandom);
        ev.ceil_ok = 1'($urandom);
        if (pick >= 85)
            return;
        // meter time moves forward, now and then slips back
        if ($urandom_range(0, 19) == 0 && ms_now > 48'd2000)
            ms_now = ms_now - 48'($urandom_range(1, 2000));
        else
            ms_now = ms_now + 48'($urandom_range(0, 2 * int'(cfg_interval) + 50));
        ev.now = ms_now;
        delta  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 400) - 200
                                             : $urandom_range(0, 128) - 64;
        if (!in_scene || pick >= 82) begin
            ev.action  = ACT_START;
            ev.req     = 17'($urandom_range(0, 49152) - 36864);
            ev.ceil    = 17'($urandom_range(0, 49152) - 36864);
            ev.req_ok  = ($urandom_range(0, 19) != 0);
            ev.ceil_ok = ($urandom_range(0, 19) != 0);
        end else if (pick < 70) begin
            ev.action  = ACT_PEAK;
            ev.peak    = 17'(limiter_held + $urandom_range(0, 4000) - 600);
            ev.peak_ok = ($urandom_range(0, 19) != 0);
            ev.req     = 17'(last_cmd + delta);
            ev.req_ok  = ($urandom_range(0, 19) != 0);
        end else begin
            ev.action  = ACT_FINISH;
            ev.req     = 17'(last_cmd + delta);
            ev.req_ok  = ($urandom_range(0, 19) != 0);
            ev.ceil    = 17'($urandom_range(0, 49152) - 36864);
            ev.ceil_ok = ($urandom_range(0, 9) != 0);
        end
    endtask

    // presents one event and holds it until taken, then files its response
    task automatic offer_event(t_event ev, t_response want);
        while (!steady && $urandom_range(0, 99) < 20) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_action          <= ev.action;
        i_peak_level      <= ev.peak;
        i_peak_valid      <= ev.peak_ok;
        i_now_time        <= ev.now;
        i_requested_level <= ev.req;
        i_requested_valid <= ev.req_ok;
        i_ceiling_level   <= ev.ceil;
        i_ceiling_valid   <= ev.ceil_ok;
        do
            @(posedge i_clk);
        while (o_stall);
        pending_responses.push_back(want);
    endtask

    // sender holds off until every response is back
    task automatic drain;
        i_valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(t_cfg_idx idx, logic [15:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
    endtask

    // writes all six registers and mirrors them into the predictor
    task automatic apply_setting(t_setting s);
        write_register(CFG_SCENE_VERSION, 16'(s.version));
        write_register(CFG_LIMITER_LEVEL, 16'(s.limiter));
        write_register(CFG_AUTO_ENABLE, 16'(s.auto_en));
        write_register(CFG_HYSTERESIS, 16'(s.hyst));
        write_register(CFG_MAX_STEP, 16'(s.step));
        write_register(CFG_MIN_INTERVAL, 16'(s.interval));
        i_cfg_we     <= 1'b0;
        cfg_version  = s.version & 8'hFF;
        cfg_limiter  = s.limiter;
        cfg_auto     = s.auto_en;
        cfg_hyst     = s.hyst;
        cfg_step     = s.step;
        cfg_interval = 16'(s.interval);
    endtask

    // result side: random stall, in-order compare against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_responses.size() == 0) begin
                errors++;
                $display("%0t: result with none expected: kind %0d target %0d safety %0d",
                         $time, o_result_kind, o_target_level, o_from_safety);
            end else begin
                got_want = pending_responses.pop_front();
                if (o_result_kind !== got_want.kind || o_target_level !== got_want.target ||
                    o_from_safety !== got_want.safety) begin
                    errors++;
                    $display({"%0t: mismatch: expected kind %0d target %0d safety %0d,",
                              " got kind %0d target %0d safety %0d"},
                             $time, got_want.kind, got_want.target, got_want.safety,
                             o_result_kind, o_target_level, o_from_safety);
                end
            end
        end
        if (i_rst_n)
            i_stall <= !steady && ($urandom_range(0, 99) < 20);
        else
            i_stall <= 1'b0;
    end

    // directed events, run with the register defaults after reset
    t_row     dir_rows [26];
    t_setting phases   [9];

    initial begin
        t_event    ev;
        t_response want;
        t_setting  s;

        dir_rows = '{
            // peak and finish while no scene is open, then the unused action code
            '{ACT_PEAK,   1000,   1, 1000,   0,      1, 0,      1, 1, KIND_NONE,     0},
            '{ACT_FINISH, 0,      1, 1000,   0,      1, 0,      1, 1, KIND_NONE,     0},
            '{ACT_NONE,   12288,  1, 2000,   0,      1, 0,      1, 1, KIND_NONE,     0},
            // start with a non-finite volume or ceiling is refused
            '{ACT_START,  0,      0, 0,      0,      0, 0,      1, 1, KIND_REJECTED, 0},
            '{ACT_START,  0,      0, 0,      0,      1, 0,      0, 1, KIND_REJECTED, 0},
            '{ACT_START,  0,      0, 0,      -2560,  1, 0,      1, 1, KIND_STARTED,  0},
            // full-scale peak, step capped
            '{ACT_PEAK,   12288,  1, 1000,   -2560,  1, 0,      1, 0, KIND_NONE,     0},
            // too soon, time running backwards, non-finite peak, peak right at threshold
            '{ACT_PEAK,   12288,  1, 1100,   -3328,  1, 0,      1, 0, KIND_NONE,     0},
            '{ACT_PEAK,   12288,  1, 500,    -3328,  1, 0,      1, 0, KIND_NONE,     0},
            '{ACT_PEAK,   12288,  0, 5000,   -3328,  1, 0,      1, 0, KIND_NONE,     0},
            '{ACT_PEAK,   -128,   1, 5000,   -3328,  1, 0,      1, 0, KIND_NONE,     0},
            // user moved the volume: override, then nothing more happens
            '{ACT_PEAK,   12288,  1, 6000,   -3200,  1, 0,      1, 0, KIND_NONE,     0},
            '{ACT_PEAK,   12288,  1, 7000,   -3328,  1, 0,      1, 0, KIND_NONE,     0},
            '{ACT_FINISH, 0,      1, 7000,   -3328,  1, 0,      1, 0, KIND_NONE,     0},
            // volume already at the floor
            '{ACT_START,  0,      1, 0,      1000,   1, -36864, 1, 1, KIND_STARTED,  0},
            '{ACT_PEAK,   12288,  1, 1000,   -36864, 1, 0,      1, 0, KIND_NONE,     0},
            // attenuate at the last millisecond, restore with a non-finite ceiling
            '{ACT_START,  0,      1, 0,      0,      1, 12288,  1, 1, KIND_STARTED,  0},
            '{ACT_PEAK,   2000,   1, 64'hFFFF_FFFF_FFFF, 0, 1, 0, 1, 0, KIND_NONE,     0},
            '{ACT_FINISH, 0,      1, 0,      -768,   1, 0,      0, 0, KIND_NONE,     0},
            // field extremes, then a non-finite volume on a peak
            '{ACT_START,  0,      1, 0,      -65536, 1, 65535,  1, 1, KIND_STARTED,  0},
            '{ACT_PEAK,   12288,  1, 100,    -65536, 0, 0,      1, 0, KIND_NONE,     0},
            '{ACT_FINISH, 0,      1, 200,    -65536, 1, 0,      1, 0, KIND_NONE,     0},
            // restore capped at a lower ceiling
            '{ACT_START,  0,      1, 0,      0,      1, 0,      1, 1, KIND_STARTED,  0},
            '{ACT_PEAK,   12288,  1, 300,    0,      1, 0,      1, 0, KIND_NONE,     0},
            '{ACT_FINISH, 0,      1, 400,    -768,   1, -500,   1, 0, KIND_NONE,     0},
            '{ACT_PEAK,   -65536, 1, 0,      0,      1, 0,      1, 1, KIND_NONE,     0}
        };

        // version, limiter, auto, hysteresis, step, interval, items, roll
        phases = '{
            '{1,   -256,   1, 128,  768,  250,   150, 0},
            '{1,   -6144,  1, 0,    6144, 0,     200, 0},
            '{1,   0,      1, 2560, 0,    65535, 120, 0},
            '{1,   -1024,  0, 64,   1024, 100,   100, 0},
            '{0,   -12288, 1, 128,  768,  250,   40,  0},
            '{255, 3072,   1, 128,  768,  250,   40,  0},
            '{1,   -256,   1, 128,  768,  250,   150, 1},
            '{1,   -256,   1, 128,  768,  250,   150, 1},
            '{1,   -6144,  1, 2560, 6144, 65535, 60,  0}
        };

        // predictor starts from the reset values
        cfg_version   = 1;
        cfg_limiter   = -256;
        cfg_auto      = 1'b1;
        cfg_hyst      = 128;
        cfg_step      = 768;
        cfg_interval  = 16'd250;
        in_scene      = 1'b0;
        auto_on       = 1'b0;
        override_flag = 1'b0;
        base_level    = 0;
        last_cmd      = 0;
        limiter_held  = 0;
        last_atten_ms = '0;
        errors        = 0;
        steady        = 1'b0;
        ms_now        = '0;

        // every input known from time zero, reset held low before the directed part
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= '0;
        i_cfg_data        <= '0;
        i_valid           <= 1'b0;
        i_action          <= '0;
        i_peak_level      <= '0;
        i_peak_valid      <= 1'b0;
        i_now_time        <= '0;
        i_requested_level <= '0;
        i_requested_valid <= 1'b0;
        i_ceiling_level   <= '0;
        i_ceiling_valid   <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part: hand-written response where typed, predictor otherwise
        foreach (dir_rows[r]) begin
            ev.action  = dir_rows[r].action;
            ev.peak    = 17'(dir_rows[r].peak);
            ev.peak_ok = dir_rows[r].peak_ok;
            ev.now     = 48'(dir_rows[r].now);
            ev.req     = 17'(dir_rows[r].req);
            ev.req_ok  = dir_rows[r].req_ok;
            ev.ceil    = 17'(dir_rows[r].ceil);
            ev.ceil_ok = dir_rows[r].ceil_ok;
            want = scene_response(ev);
            if (dir_rows[r].typed)
                want = '{dir_rows[r].kind, 17'(dir_rows[r].target), 1'b0};
            offer_event(ev, want);
        end

        // random phases; registers change only once the block has drained
        foreach (phases[p]) begin
            drain();
            s = phases[p];
            if (s.roll) begin
                s.version  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : 1;
                s.limiter  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15360) - 12288
                                                         : -$urandom_range(0, 6144);
                s.auto_en  = ($urandom_range(0, 9) != 0);
                s.hyst     = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2560)
                                                         : $urandom_range(0, 512);
                s.step     = $urandom_range(0, 6144);
                s.interval = $urandom_range(0, 1000);
            end
            apply_setting(s);
            steady = (p == 1);
            repeat (s.items) begin
                make_event(ev);
                want = scene_response(ev);
                offer_event(ev, want);
            end
        end

        // let every response come back, then let the block sit quiet before the verdict
        i_valid <= 1'b0;
        steady  = 1'b0;
        while (pending_responses.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0)
            $display("scene_peak_auto_attenuator test passed");
        else
            $display("scene_peak_auto_attenuator test failed");
        $finish;
    end

endmodule
